FILE: hdl/psea_pkg.sv
// psea_pkg: shared types and constants of the paged slot extend allocator
// used by every module under hdl; depends on nothing

package psea_pkg;

  localparam int PAGE_W   = 11;
  localparam int LEN_W    = 20;
  localparam int POS_W    = 24;
  localparam int SLOT_W   = 32;
  localparam int LSLOT_W  = 33;
  localparam int PAGENO_W = 22;
  localparam int ST_W     = 2;

  localparam logic [PAGE_W-1:0] PAGE_RESET = 11'd16;
  localparam logic [PAGE_W-1:0] PAGE_MAX   = 11'd1024;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_SHORT   = 2'd1;
  localparam logic [ST_W-1:0] ST_TOOMANY = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

endpackage

FILE: hdl/psea_div.sv
// psea_div: shared restoring divider, one quotient bit per cycle
// divides a token count by the page size; uses psea_pkg

module psea_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [psea_pkg::LEN_W-1:0]       dividend,
  input  logic [psea_pkg::PAGE_W-1:0]      divisor,
  output psea_pkg::div_stat_t              stat,
  output logic [psea_pkg::LEN_W-1:0]       quot,
  output logic [psea_pkg::PAGE_W-1:0]      rem
);

  localparam int CNT_W = $clog2(psea_pkg::LEN_W);

  logic [psea_pkg::LEN_W-1:0]  dvd_r;
  logic [psea_pkg::PAGE_W-1:0] rem_r;
  logic [psea_pkg::PAGE_W-1:0] dsr_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [psea_pkg::PAGE_W:0]   shifted;
  logic                        fits;

  assign shifted = {rem_r, dvd_r[psea_pkg::LEN_W-1]};
  assign fits    = shifted >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? psea_pkg::PAGE_W'(shifted - {1'b0, dsr_r})
                      : shifted[psea_pkg::PAGE_W-1:0];
        dvd_r <= {dvd_r[psea_pkg::LEN_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(psea_pkg::LEN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = dvd_r;
  assign rem       = rem_r;

endmodule

FILE: hdl/psea_fifo.sv
// psea_fifo: free page fifo on a single memory with registered read data
// pointers and fill count; uses psea_pkg

module psea_fifo #(
  parameter int FREE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  psea_pkg::fifo_ctl_t                ctl,
  input  logic [psea_pkg::PAGENO_W-1:0]      push_data,
  output logic [psea_pkg::PAGENO_W-1:0]      rd_data,
  output logic [$clog2(FREE_DEPTH+1)-1:0]    count
);

  localparam int AW = $clog2(FREE_DEPTH);
  localparam int CW = $clog2(FREE_DEPTH+1);

  logic [psea_pkg::PAGENO_W-1:0] mem [FREE_DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [psea_pkg::PAGENO_W-1:0] rd_data_r;
  logic do_push;
  logic do_pop;

  // a push into a full fifo is dropped
  assign do_push = ctl.push && (count_r != CW'(FREE_DEPTH));
  assign do_pop  = ctl.pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
    if (do_pop) rd_data_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == AW'(FREE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == AW'(FREE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule

FILE: hdl/paged_slot_extend_allocator.sv
// paged_slot_extend_allocator: top level, sequencer around the shared divider
// depends on psea_pkg, psea_div and psea_fifo
//
// Input beats: tuser[0] opcode, tuser[1] batch_start. A push beat (opcode 0)
// stores a free page number. An allocate beat runs two divisions (20 quotient
// bits each) of prefix and sequence length by the page size on the one shared
// divider, then a decision step and, for a non-empty request without error, a
// check step, then emits its runs on the output channel.
// A first run, when there is one, is loaded from S_RUN1; each page run passes
// S_POP (fifo read), S_MUL (multiply by page size) and S_EMIT (load). An error
// beat ends a failed request, and an empty extension goes back to idle with no
// beat.
// Each result is held in an output register until the receiver takes it; a
// stalled receiver holds the sequencer, and the next input beat is taken as
// soon as the last run of a request sits in the output register.
// tlast marks the final run or the error beat of a request; tuser holds status.
// cfg_wr_en writes the page size (reset 16) and is meant only while idle.
// Reset is synchronous: fifo empty, running position zero, output empty.

module paged_slot_extend_allocator #(
  parameter int FREE_DEPTH    = 1024,
  parameter int MAX_NEW_PAGES = 62
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,   // tokens per page
  input  logic        in_tvalid,
  output logic        in_tready,
  // free_page[21:0], prefix_len[41:22], seq_len[61:42], last_slot[93:62], zero pad
  input  logic [95:0] in_tdata,
  // opcode[0], batch_start[1]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_position[23:0], slot_start[55:24], run_length[66:56], zero pad
  output logic [71:0] out_tdata,
  // status[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast   // last_of_request
);

  localparam int CW = $clog2(FREE_DEPTH+1);
  localparam int NW = $clog2(MAX_NEW_PAGES+1);
  localparam int PW = psea_pkg::PAGE_W;
  localparam int LW = psea_pkg::LEN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVP, S_DIVS, S_CHECK, S_ERR, S_RUN1, S_POP, S_MUL, S_EMIT
  } state_t;

  state_t state_r;

  logic [PW-1:0] page_r;
  logic [PW-1:0] p_eff;
  logic [LW-1:0] pref_r, seq_r;
  logic [31:0]   last_r;
  logic [LW-1:0] qp_r;
  logic [PW-1:0] rp_r;
  logic [psea_pkg::POS_W-1:0] pos_r;
  logic [psea_pkg::ST_W-1:0]  err_r;
  logic [PW-1:0] num1_r, num3_r;
  logic [NW-1:0] nfull_r;
  logic [31:0]   prod_r;

  logic out_valid_r, out_last_r;
  logic [psea_pkg::ST_W-1:0]   out_st_r;
  logic [psea_pkg::POS_W-1:0]  out_pos_r;
  logic [31:0]                 out_slot_r;
  logic [PW-1:0]               out_len_r;

  psea_pkg::div_stat_t div_stat;
  logic          div_start;
  logic [LW-1:0] div_dvd;
  logic [LW-1:0] div_q;
  logic [PW-1:0] div_r;

  psea_pkg::fifo_ctl_t fifo_ctl;
  logic [psea_pkg::PAGENO_W-1:0] fifo_rd;
  logic [CW-1:0] fifo_cnt;

  logic in_acc, out_busy, emit;
  logic [LW:0]   ceil_pref, ceil_seq, num_new;
  logic [LW-1:0] ext_len;
  logic [PW:0]   to_bound;
  logic [PW-1:0] num1_c, num3_c, run_len;
  logic [LW:0]   nfull_c;
  logic          more_after;

  always_comb begin
    if (page_r == '0)          p_eff = PW'(1);
    else if (page_r > psea_pkg::PAGE_MAX) p_eff = psea_pkg::PAGE_MAX;
    else                       p_eff = page_r;
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;
  // a beat is loaded into the output register this cycle
  assign emit      = !out_busy && (state_r inside {S_ERR, S_RUN1, S_EMIT});

  assign div_start = (in_acc && in_tuser[0] == psea_pkg::OP_ALLOC) ||
                     (state_r == S_DIVP && div_stat.done);
  assign div_dvd   = (state_r == S_IDLE) ? in_tdata[41:22] : seq_r;

  psea_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(p_eff), .stat(div_stat), .quot(div_q), .rem(div_r)
  );

  assign fifo_ctl.push = in_acc && in_tuser[0] == psea_pkg::OP_PUSH;
  assign fifo_ctl.pop  = (state_r == S_POP);

  psea_fifo #(.FREE_DEPTH(FREE_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .ctl(fifo_ctl), .push_data(in_tdata[21:0]),
    .rd_data(fifo_rd), .count(fifo_cnt)
  );

  // in S_DIVS with done, the seq quotient is on div_q / div_r
  assign ceil_pref = {1'b0, qp_r} + (LW+1)'(rp_r != '0);
  assign ceil_seq  = {1'b0, div_q} + (LW+1)'(div_r != '0);
  assign num_new   = ceil_seq - ceil_pref;
  assign ext_len   = seq_r - pref_r;
  assign to_bound  = {1'b0, p_eff} - {1'b0, rp_r};
  always_comb begin
    if (rp_r == '0) num1_c = '0;
    else if ((LW+1)'(to_bound) > {1'b0, ext_len}) num1_c = ext_len[PW-1:0];
    else num1_c = to_bound[PW-1:0];
  end
  assign nfull_c = {1'b0, div_q} - ceil_pref;
  assign num3_c  = ({1'b0, div_q} >= ceil_pref) ? div_r : '0;

  // in S_EMIT: does another page run follow this one
  assign run_len    = (nfull_r != '0) ? p_eff : num3_r;
  assign more_after = (nfull_r > NW'(1)) || (nfull_r == NW'(1) && num3_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      page_r      <= psea_pkg::PAGE_RESET;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) page_r <= cfg_wr_data;
      if (emit) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_tuser[0] == psea_pkg::OP_ALLOC) begin
            pref_r <= in_tdata[41:22];
            seq_r  <= in_tdata[61:42];
            last_r <= in_tdata[93:62];
            if (in_tuser[1]) pos_r <= '0;
            state_r <= S_DIVP;
          end
        end
        S_DIVP: begin
          if (div_stat.done) begin
            qp_r    <= div_q;
            rp_r    <= div_r;
            state_r <= S_DIVS;
          end
        end
        S_DIVS: begin
          if (div_stat.done) begin
            num1_r  <= num1_c;
            num3_r  <= num3_c;
            nfull_r <= nfull_c[LW] ? '0 : NW'(nfull_c);
            if (seq_r < pref_r) begin
              err_r <= psea_pkg::ST_SHORT;   state_r <= S_ERR;
            end else if (num_new > (LW+1)'(MAX_NEW_PAGES)) begin
              err_r <= psea_pkg::ST_TOOMANY; state_r <= S_ERR;
            end else if (num_new > (LW+1)'(fifo_cnt)) begin
              err_r <= psea_pkg::ST_EMPTY;   state_r <= S_ERR;
            end else if (seq_r == pref_r) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          state_r <= (num1_r != '0) ? S_RUN1 : S_POP;
        end
        S_ERR: begin
          if (!out_busy) begin
            out_st_r    <= err_r;
            out_pos_r   <= pos_r;
            out_slot_r  <= '0;
            out_len_r   <= '0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_RUN1: begin
          if (!out_busy) begin
            out_st_r    <= psea_pkg::ST_OK;
            out_pos_r   <= pos_r;
            out_slot_r  <= last_r + 32'd1;
            out_len_r   <= num1_r;
            out_last_r  <= (nfull_r == '0) && (num3_r == '0);
            pos_r       <= pos_r + psea_pkg::POS_W'(num1_r);
            state_r     <= ((nfull_r == '0) && (num3_r == '0)) ? S_IDLE : S_POP;
          end
        end
        S_POP: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= 32'(fifo_rd * p_eff);
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_busy) begin
            out_st_r    <= psea_pkg::ST_OK;
            out_pos_r   <= pos_r;
            out_slot_r  <= prod_r;
            out_len_r   <= run_len;
            out_last_r  <= !more_after;
            pos_r       <= pos_r + psea_pkg::POS_W'(run_len);
            if (nfull_r != '0) nfull_r <= nfull_r - 1'b1;
            else               num3_r  <= '0;
            state_r     <= more_after ? S_POP : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_len_r, out_slot_r, out_pos_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hdl/psea_checker.sv
// psea_checker: port-level assertions for the allocator, bound to the top level
// uses psea_pkg status codes

module psea_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped while stalled");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != psea_pkg::ST_OK |-> out_tlast && out_tdata[66:24] == '0)
    else $error("error beat not a single empty last beat");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == psea_pkg::ST_OK |-> out_tdata[66:56] != '0)
    else $error("ok run of zero length");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind paged_slot_extend_allocator psea_checker u_psea_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
